### rtl/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg
// Shared types, widths and codes for the sprite animation sequencer.
// ----------------------------------------------------------------------------
package sas_pkg;

	localparam int FRAME_BITS     = 10;
	localparam int TIME_FRAC_BITS = 16;

	localparam int ACC_BITS    = TIME_FRAC_BITS + 10;
	localparam int DELAY_BITS  = 24;
	localparam int DT_BITS     = 20;
	localparam int NF_BITS     = 11;
	localparam int COLS_BITS   = 8;
	localparam int SIZE_BITS   = 12;
	localparam int LEFT_BITS   = 20;
	localparam int TOP_BITS    = 22;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 24;

	// Common width for the accumulator sum and the delay compare.
	localparam int WIDE_MAX  = (ACC_BITS > DELAY_BITS) ? ACC_BITS : DELAY_BITS;
	localparam int WIDE_BITS = ((WIDE_MAX > DT_BITS) ? WIDE_MAX : DT_BITS) + 1;

	// Divider step counter.
	localparam int CNT_BITS = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;

	localparam logic [ACC_BITS-1:0]   ACC_MAX     = '1;
	localparam logic [DELAY_BITS-1:0] DELAY_RESET = DELAY_BITS'(64'd1 << TIME_FRAC_BITS);

	// Item kinds.
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_SET  = 1'b1;

	// Register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_START_FRAME   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_END_FRAME     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_DELAY   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOOP_MODE     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_COLUMNS       = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPRITE_WIDTH  = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPRITE_HEIGHT = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_ADVANCE,
		ST_DIV_INIT,
		ST_DIV,
		ST_MUL,
		ST_LOAD
	} sas_state_t;

	typedef struct packed {
		logic load_item;
		logic accum;
		logic advance;
		logic div_init;
		logic div_step;
		logic mul;
		logic load_out;
	} sas_cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_free;
	} sas_sts_t;

endpackage

### rtl/sas_if.sv
// ----------------------------------------------------------------------------
// sas_if
// Channel interfaces: input items, result items and register writes.
// ----------------------------------------------------------------------------
interface sas_item_if;
	import sas_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [DT_BITS-1:0]        elapsed_time;
	logic signed [NF_BITS-1:0] new_frame;

	modport source (output valid, kind, elapsed_time, new_frame, input ready);
	modport sink (input valid, kind, elapsed_time, new_frame, output ready);
endinterface

interface sas_result_if;
	import sas_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [FRAME_BITS-1:0] frame_index;
	logic                  done_flag;
	logic [LEFT_BITS-1:0]  rect_left;
	logic [TOP_BITS-1:0]   rect_top;
	logic [LEFT_BITS-1:0]  rect_right;
	logic [TOP_BITS-1:0]   rect_bottom;

	modport source (output valid, frame_index, done_flag, rect_left, rect_top,
		rect_right, rect_bottom, input ready);
	modport sink (input valid, frame_index, done_flag, rect_left, rect_top,
		rect_right, rect_bottom, output ready);
endinterface

interface sas_cfg_if;
	import sas_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/sas_ctrl.sv
// ----------------------------------------------------------------------------
// sas_ctrl
// Sequencer: steps one item through update, divide, multiply and load.
// ----------------------------------------------------------------------------
module sas_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  sas_pkg::sas_sts_t sts,
	output sas_pkg::sas_cmd_t cmd
);
	import sas_pkg::*;

	sas_state_t state_q;
	sas_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_d   = ST_ADVANCE;
			end
			ST_ADVANCE: begin
				cmd.advance = 1'b1;
				state_d     = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				// wait until the result register is free or being drained
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded while the output register is occupied");

	a_init_then_divide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_init |=> (state_q == ST_DIV))
		else $error("divider init not followed by divide steps");

	a_accept_starts_item: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> (state_q == ST_ACCUM))
		else $error("accepted item did not start processing");

endmodule

### rtl/sas_datapath.sv
// ----------------------------------------------------------------------------
// sas_datapath
// Registers, timer and frame update, serial divider, rectangle and output.
// ----------------------------------------------------------------------------
module sas_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sas_pkg::sas_cmd_t                  cmd,
	output sas_pkg::sas_sts_t                  sts,
	input  logic                               cfg_we,
	input  logic [sas_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [sas_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               in_kind,
	input  logic [sas_pkg::DT_BITS-1:0]        in_elapsed_time,
	input  logic signed [sas_pkg::NF_BITS-1:0] in_new_frame,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [sas_pkg::FRAME_BITS-1:0]     out_frame_index,
	output logic                               out_done_flag,
	output logic [sas_pkg::LEFT_BITS-1:0]      out_rect_left,
	output logic [sas_pkg::TOP_BITS-1:0]       out_rect_top,
	output logic [sas_pkg::LEFT_BITS-1:0]      out_rect_right,
	output logic [sas_pkg::TOP_BITS-1:0]       out_rect_bottom
);
	import sas_pkg::*;

	// configuration registers
	logic [FRAME_BITS-1:0] start_frame_q;
	logic [FRAME_BITS-1:0] end_frame_q;
	logic [DELAY_BITS-1:0] frame_delay_q;
	logic                  loop_mode_q;
	logic [COLS_BITS-1:0]  columns_q;
	logic [SIZE_BITS-1:0]  sprite_width_q;
	logic [SIZE_BITS-1:0]  sprite_height_q;

	// animation state
	logic [ACC_BITS-1:0]   acc_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic                  complete_q;

	// latched item
	logic                  kind_q;
	logic [DT_BITS-1:0]    dt_q;
	logic [NF_BITS-1:0]    nf_q;

	// divider
	logic [FRAME_BITS-1:0] quo_q;
	logic [COLS_BITS-1:0]  rem_q;
	logic [CNT_BITS-1:0]   cnt_q;

	// products
	logic [LEFT_BITS-1:0]  left_q;
	logic [TOP_BITS-1:0]   top_q;

	// result register
	logic                  out_valid_q;
	logic [FRAME_BITS-1:0] res_frame_q;
	logic                  res_done_q;
	logic [LEFT_BITS-1:0]  res_left_q;
	logic [TOP_BITS-1:0]   res_top_q;
	logic [LEFT_BITS-1:0]  res_right_q;
	logic [TOP_BITS-1:0]   res_bottom_q;

	logic                  animated;
	logic                  is_tick;
	logic [WIDE_BITS-1:0]  acc_sum;
	logic [ACC_BITS-1:0]   acc_sat;
	logic                  acc_over;
	logic [FRAME_BITS:0]   frame_inc;
	logic                  out_of_range;
	logic [COLS_BITS-1:0]  divisor;
	logic [COLS_BITS:0]    trial;
	logic                  trial_ge;
	logic [COLS_BITS+SIZE_BITS-1:0]  left_prod;
	logic [FRAME_BITS+SIZE_BITS-1:0] top_prod;

	assign animated = end_frame_q > start_frame_q;
	assign is_tick  = (kind_q == KIND_TICK);

	assign acc_sum  = WIDE_BITS'(acc_q) + WIDE_BITS'(dt_q);
	assign acc_sat  = (acc_sum > WIDE_BITS'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_BITS-1:0];
	assign acc_over = WIDE_BITS'(acc_q) > WIDE_BITS'(frame_delay_q);

	assign frame_inc    = {1'b0, frame_q} + (FRAME_BITS+1)'(1);
	assign out_of_range = (frame_inc < {1'b0, start_frame_q}) ||
		(frame_inc > {1'b0, end_frame_q});

	// zero columns behaves as one
	assign divisor  = (columns_q == '0) ? COLS_BITS'(1) : columns_q;
	assign trial    = {rem_q, quo_q[FRAME_BITS-1]};
	assign trial_ge = trial >= {1'b0, divisor};

	assign left_prod = (COLS_BITS+SIZE_BITS)'(rem_q) *
		(COLS_BITS+SIZE_BITS)'(sprite_width_q);
	assign top_prod  = (FRAME_BITS+SIZE_BITS)'(quo_q) *
		(FRAME_BITS+SIZE_BITS)'(sprite_height_q);

	assign sts.div_last = (cnt_q == '0);
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_frame_q   <= '0;
			end_frame_q     <= '0;
			frame_delay_q   <= DELAY_RESET;
			loop_mode_q     <= 1'b1;
			columns_q       <= COLS_BITS'(1);
			sprite_width_q  <= SIZE_BITS'(2);
			sprite_height_q <= SIZE_BITS'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_FRAME:   start_frame_q   <= FRAME_BITS'(cfg_data);
				REG_END_FRAME:     end_frame_q     <= FRAME_BITS'(cfg_data);
				REG_FRAME_DELAY:   frame_delay_q   <= DELAY_BITS'(cfg_data);
				REG_LOOP_MODE:     loop_mode_q     <= cfg_data[0];
				REG_COLUMNS:       columns_q       <= cfg_data[COLS_BITS-1:0];
				REG_SPRITE_WIDTH:  sprite_width_q  <= cfg_data[SIZE_BITS-1:0];
				REG_SPRITE_HEIGHT: sprite_height_q <= cfg_data[SIZE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			frame_q    <= '0;
			complete_q <= 1'b0;
		end else begin
			if (cmd.accum && is_tick && animated) begin
				acc_q <= acc_sat;
			end
			if (cmd.advance) begin
				if (is_tick) begin
					if (animated && acc_over) begin
						acc_q <= ACC_BITS'(WIDE_BITS'(acc_q) - WIDE_BITS'(frame_delay_q));
						if (!out_of_range) begin
							frame_q <= frame_inc[FRAME_BITS-1:0];
						end else if (loop_mode_q) begin
							frame_q <= start_frame_q;
						end else begin
							frame_q    <= end_frame_q;
							complete_q <= 1'b1;
						end
					end
				end else if (!nf_q[NF_BITS-1]) begin
					// negative set requests are dropped
					frame_q    <= FRAME_BITS'(nf_q[NF_BITS-2:0]);
					complete_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= in_kind;
			dt_q   <= in_elapsed_time;
			nf_q   <= in_new_frame;
		end
		if (cmd.div_init) begin
			quo_q <= frame_q;
			rem_q <= '0;
			cnt_q <= CNT_BITS'(FRAME_BITS - 1);
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[FRAME_BITS-2:0], trial_ge};
			rem_q <= trial_ge ? COLS_BITS'(trial - {1'b0, divisor}) : trial[COLS_BITS-1:0];
			cnt_q <= cnt_q - CNT_BITS'(1);
		end
		if (cmd.mul) begin
			left_q <= LEFT_BITS'(left_prod);
			top_q  <= TOP_BITS'(top_prod);
		end
		if (cmd.load_out) begin
			res_frame_q  <= frame_q;
			res_done_q   <= complete_q;
			res_left_q   <= left_q;
			res_top_q    <= top_q;
			res_right_q  <= left_q + LEFT_BITS'(sprite_width_q);
			res_bottom_q <= top_q + TOP_BITS'(sprite_height_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_frame_index = res_frame_q;
	assign out_done_flag   = res_done_q;
	assign out_rect_left   = res_left_q;
	assign out_rect_top    = res_top_q;
	assign out_rect_right  = res_right_q;
	assign out_rect_bottom = res_bottom_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |-> (rem_q < divisor))
		else $error("divider remainder not below the column count");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not presented");

	a_done_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(complete_q) |-> (frame_q == end_frame_q))
		else $error("one-shot completion without clamping to the end frame");

endmodule

### rtl/sprite_animation_sequencer.sv
// ----------------------------------------------------------------------------
// sprite_animation_sequencer
// Sprite-sheet frame animation timer with source rectangle output.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                      | transfer when
//  ---------+-----+----------------------------------------------+---------------
//  item     | in  | kind, elapsed_time, new_frame                | valid & ready
//  result   | out | frame_index, done_flag, rect_left/top/       | valid & ready
//           |     | right/bottom                                 |
//  cfg      | in  | index, data (register write)                 | valid & ready
//
//  Each item runs from transfer to a loaded result through accumulate,
//  advance, divider init, FRAME_BITS divide steps, multiply and load. The
//  serial restoring divider gives one quotient bit per cycle. A new item
//  transfers in only while the sequencer is idle, after the last item
//  has been loaded into the result register.
//  The result register lets the next item transfer in while a result waits;
//  that item stalls in its last step until the result is taken.
//  arst_n clears the sequencer, the animation state and the registers to
//  their defaults; no clearing pass is needed. cfg is always ready.
// ----------------------------------------------------------------------------
module sprite_animation_sequencer (
	input  logic         clk,
	input  logic         arst_n,
	sas_item_if.sink     item,
	sas_result_if.source result,
	sas_cfg_if.sink      cfg
);
	import sas_pkg::*;

	sas_cmd_t cmd;
	sas_sts_t sts;

	// register writes land without a wait state, so never hold the write channel
	assign cfg.ready = 1'b1;

	sas_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	sas_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg.valid && cfg.ready),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.in_kind         (item.kind),
		.in_elapsed_time (item.elapsed_time),
		.in_new_frame    (item.new_frame),
		.out_valid       (result.valid),
		.out_ready       (result.ready),
		.out_frame_index (result.frame_index),
		.out_done_flag   (result.done_flag),
		.out_rect_left   (result.rect_left),
		.out_rect_top    (result.rect_top),
		.out_rect_right  (result.rect_right),
		.out_rect_bottom (result.rect_bottom)
	);

endmodule

### bench/sprite_animation_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_animation_sequencer_tb
// Self-checking bench for the sprite animation sequencer. A model of the
// frame timer and of the sheet rectangle runs beside the block. Every item
// that is transferred in is predicted there, and every result that is
// transferred out is compared field by field with the oldest prediction.
// Directed tests cover the register extremes and the corner cases. Random
// phases follow, with idle patterns on both channels and one long
// receiver stall.
// ----------------------------------------------------------------------------
module sprite_animation_sequencer_tb;
	import sas_pkg::*;

	localparam int CYCLE_LIMIT       = 400000;
	localparam int SETTLE_CYCLES     = 24;
	localparam int LONG_STALL_CYCLES = 320;
	localparam int MAX_REPORTS       = 60;
	localparam int PHASE_ITEMS       = 420;

	// Index with no register behind it; writes there must be dropped.
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [FRAME_BITS-1:0] frame_index;
		logic                  done_flag;
		logic [LEFT_BITS-1:0]  rect_left;
		logic [TOP_BITS-1:0]   rect_top;
		logic [LEFT_BITS-1:0]  rect_right;
		logic [TOP_BITS-1:0]   rect_bottom;
	} sprite_rect_t;

	logic clk;
	logic arst_n;

	sas_item_if   item_ch ();
	sas_result_if res_ch ();
	sas_cfg_if    cfg_ch ();

	sprite_animation_sequencer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// Copy of the register file as the block should see it.
	logic [FRAME_BITS-1:0] sheet_start;
	logic [FRAME_BITS-1:0] sheet_end;
	logic [DELAY_BITS-1:0] sheet_delay;
	logic                  sheet_loop;
	logic [COLS_BITS-1:0]  sheet_cols;
	logic [SIZE_BITS-1:0]  sheet_width;
	logic [SIZE_BITS-1:0]  sheet_height;

	// Copy of the animation state.
	logic [ACC_BITS-1:0]   anim_acc;
	logic [FRAME_BITS-1:0] anim_frame;
	logic                  anim_done;

	// Rectangles predicted but not yet seen on the result channel.
	sprite_rect_t pending_rects[$];

	int unsigned fail_count = 0;
	int unsigned cycle_count;
	int unsigned src_idle_pct;
	int unsigned sink_idle_pct;
	int unsigned stall_requests;
	int unsigned stall_granted = 0;
	int unsigned stall_left = 0;

	sprite_rect_t seen_rect;
	sprite_rect_t want_rect;

	// ------------------------------------------------------------------------
	// Clock, reset and the starting value of every block input
	// ------------------------------------------------------------------------
	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		arst_n                = 1'b0;
		item_ch.valid        <= 1'b0;
		item_ch.kind         <= KIND_TICK;
		item_ch.elapsed_time <= '0;
		item_ch.new_frame    <= '0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.index         <= REG_START_FRAME;
		cfg_ch.data          <= '0;
	end

	// Watchdog: a run that hangs anywhere ends here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("sprite_animation_sequencer verification failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Model of the block
	// ------------------------------------------------------------------------

	// Set the model to its state after reset.
	task automatic reset_sheet_model();
		sheet_start  = '0;
		sheet_end    = '0;
		sheet_delay  = DELAY_RESET;
		sheet_loop   = 1'b1;
		sheet_cols   = 8'd1;
		sheet_width  = 12'd2;
		sheet_height = 12'd2;
		anim_acc     = '0;
		anim_frame   = '0;
		anim_done    = 1'b0;
	endtask

	// Advance the animation by one item and queue the rectangle it reports.
	task automatic predict_sprite_rect(input logic kind, input logic [DT_BITS-1:0] dt,
			input logic [NF_BITS-1:0] nf);
		logic [ACC_BITS:0]   sum;
		logic [FRAME_BITS:0] nxt;
		int unsigned         div_cols;
		int unsigned         left;
		int unsigned         top;
		sprite_rect_t        rect;

		if (kind == KIND_TICK) begin
			// Only a real range animates; otherwise even the timer holds.
			if (sheet_end > sheet_start) begin
				sum = {1'b0, anim_acc} + (ACC_BITS+1)'(dt);
				if (sum > {1'b0, ACC_MAX}) begin
					sum = {1'b0, ACC_MAX};
				end
				anim_acc = sum[ACC_BITS-1:0];
				if (anim_acc > ACC_BITS'(sheet_delay)) begin
					anim_acc = anim_acc - ACC_BITS'(sheet_delay);
					// One bit wider, so the top index counts as out of range.
					nxt = {1'b0, anim_frame} + (FRAME_BITS+1)'(1);
					if (nxt < {1'b0, sheet_start} || nxt > {1'b0, sheet_end}) begin
						if (sheet_loop) begin
							nxt = {1'b0, sheet_start};
						end else begin
							nxt = {1'b0, sheet_end};
							anim_done = 1'b1;
						end
					end
					anim_frame = nxt[FRAME_BITS-1:0];
				end
			end
		end else if (!nf[NF_BITS-1]) begin
			anim_frame = nf[FRAME_BITS-1:0];
			anim_done  = 1'b0;
		end

		div_cols = (sheet_cols == '0) ? 32'd1 : 32'(sheet_cols);
		left     = (32'(anim_frame) % div_cols) * 32'(sheet_width);
		top      = (32'(anim_frame) / div_cols) * 32'(sheet_height);

		rect.frame_index = anim_frame;
		rect.done_flag   = anim_done;
		rect.rect_left   = LEFT_BITS'(left);
		rect.rect_top    = TOP_BITS'(top);
		rect.rect_right  = LEFT_BITS'(left + 32'(sheet_width));
		rect.rect_bottom = TOP_BITS'(top + 32'(sheet_height));
		pending_rects.push_back(rect);
	endtask

	// ------------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------------

	// Offer one item and wait for its transfer. Valid stays high afterwards
	// so back-to-back items run without a gap; a drain, or an idle draw in
	// the next call, drops it.
	task automatic send_item(input logic kind, input logic [DT_BITS-1:0] dt,
			input logic [NF_BITS-1:0] nf);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
		end
		item_ch.valid        <= 1'b1;
		item_ch.kind         <= kind;
		item_ch.elapsed_time <= dt;
		item_ch.new_frame    <= nf;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		predict_sprite_rect(kind, dt, nf);
	endtask

	task automatic send_tick(input logic [DT_BITS-1:0] dt);
		send_item(KIND_TICK, dt, NF_BITS'($urandom));
	endtask

	task automatic send_set(input logic [NF_BITS-1:0] nf);
		send_item(KIND_SET, DT_BITS'($urandom), nf);
	endtask

	// Stop offering and wait until every predicted result is back, then let
	// the block settle so that register writes find it idle.
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (pending_rects.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register. Valid drops after the transfer, before the task
	// returns, so a following write starts in a later step.
	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] index,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		case (index)
			REG_START_FRAME:   sheet_start  = data[FRAME_BITS-1:0];
			REG_END_FRAME:     sheet_end    = data[FRAME_BITS-1:0];
			REG_FRAME_DELAY:   sheet_delay  = data[DELAY_BITS-1:0];
			REG_LOOP_MODE:     sheet_loop   = data[0];
			REG_COLUMNS:       sheet_cols   = data[COLS_BITS-1:0];
			REG_SPRITE_WIDTH:  sheet_width  = data[SIZE_BITS-1:0];
			REG_SPRITE_HEIGHT: sheet_height = data[SIZE_BITS-1:0];
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Fill the bits above a register's width with noise; the block must
	// drop them.
	function automatic logic [CFG_DATA_BITS-1:0] pad_upper(
			input logic [CFG_DATA_BITS-1:0] value, input int bits);
		logic [CFG_DATA_BITS-1:0] keep;
		keep = (CFG_DATA_BITS'(1) << bits) - CFG_DATA_BITS'(1);
		return (CFG_DATA_BITS'($urandom) & ~keep) | (value & keep);
	endfunction

	// Write every register with a fresh value. Mostly short animations with
	// delays that the ticks can reach; now and then the extremes.
	task automatic random_config();
		logic [FRAME_BITS-1:0] first;
		logic [FRAME_BITS-1:0] last;
		logic [DELAY_BITS-1:0] delay;
		logic [COLS_BITS-1:0]  cols;
		logic [SIZE_BITS-1:0]  size_w;
		logic [SIZE_BITS-1:0]  size_h;
		int unsigned           pick;

		pick  = $urandom_range(0, 9);
		first = (pick == 0) ? FRAME_BITS'($urandom_range(1012, 1023))
			: FRAME_BITS'($urandom_range(0, 40));
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			// Not animated: end at or below start.
			last = FRAME_BITS'($urandom_range(0, first));
		end else if (pick == 1 || first > 1012) begin
			last = '1;
		end else begin
			last = first + FRAME_BITS'($urandom_range(1, 10));
		end

		pick = $urandom_range(0, 19);
		case (pick)
			0:       delay = '0;
			1:       delay = '1;
			2:       delay = DELAY_BITS'($urandom);
			default: delay = DELAY_BITS'($urandom_range(1, 300));
		endcase

		pick = $urandom_range(0, 9);
		case (pick)
			0:       cols = '0;
			1:       cols = '1;
			2:       cols = COLS_BITS'($urandom);
			default: cols = COLS_BITS'($urandom_range(1, 16));
		endcase

		pick   = $urandom_range(0, 9);
		size_w = (pick == 0) ? '0 : (pick == 1) ? '1 : (pick == 2) ? SIZE_BITS'($urandom)
			: SIZE_BITS'($urandom_range(1, 64));
		pick   = $urandom_range(0, 9);
		size_h = (pick == 0) ? '0 : (pick == 1) ? '1 : (pick == 2) ? SIZE_BITS'($urandom)
			: SIZE_BITS'($urandom_range(1, 64));

		cfg_write(REG_START_FRAME, pad_upper(CFG_DATA_BITS'(first), FRAME_BITS));
		cfg_write(REG_END_FRAME, pad_upper(CFG_DATA_BITS'(last), FRAME_BITS));
		cfg_write(REG_FRAME_DELAY, delay);
		cfg_write(REG_LOOP_MODE, pad_upper(CFG_DATA_BITS'($urandom_range(0, 1)), 1));
		cfg_write(REG_COLUMNS, pad_upper(CFG_DATA_BITS'(cols), COLS_BITS));
		cfg_write(REG_SPRITE_WIDTH, pad_upper(CFG_DATA_BITS'(size_w), SIZE_BITS));
		cfg_write(REG_SPRITE_HEIGHT, pad_upper(CFG_DATA_BITS'(size_h), SIZE_BITS));
		if ($urandom_range(0, 7) == 0) begin
			cfg_write(REG_UNUSED, CFG_DATA_BITS'($urandom));
		end
	endtask

	// One random item shaped by the current registers: mostly ticks near the
	// delay, and frame sets around the animated range, with noise on top.
	task automatic send_random_item();
		logic [DT_BITS-1:0] dt;
		logic [NF_BITS-1:0] nf;
		int unsigned        pick;
		int unsigned        span;
		int unsigned        lo;
		int unsigned        hi;

		if ($urandom_range(0, 99) < 70) begin
			pick = $urandom_range(0, 19);
			span = (sheet_delay > 24'd524287) ? 32'd1048575 : 2 * 32'(sheet_delay) + 1;
			case (pick)
				0:       dt = '0;
				1:       dt = '1;
				2, 3:    dt = DT_BITS'($urandom);
				default: dt = DT_BITS'($urandom_range(0, span));
			endcase
			send_tick(dt);
		end else begin
			if ($urandom_range(0, 4) == 0) begin
				// Full range, negative values included.
				nf = NF_BITS'($urandom);
			end else begin
				lo = (sheet_start > 2) ? 32'(sheet_start) - 2 : 0;
				hi = (sheet_end > 1021) ? 1023 : 32'(sheet_end) + 2;
				nf = NF_BITS'($urandom_range(lo, hi));
			end
			send_set(nf);
		end
	endtask

	// ------------------------------------------------------------------------
	// Result receiver: random idling, plus a long stall on request that it
	// counts down itself.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (stall_requests != stall_granted) begin
				stall_granted = stall_requests;
				stall_left    = LONG_STALL_CYCLES;
			end
			if (stall_left != 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS) begin
				$display("%0t ns: %s mismatch, expected %0d, actual %0d",
					$time, name, want, got);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			seen_rect.frame_index = res_ch.frame_index;
			seen_rect.done_flag   = res_ch.done_flag;
			seen_rect.rect_left   = res_ch.rect_left;
			seen_rect.rect_top    = res_ch.rect_top;
			seen_rect.rect_right  = res_ch.rect_right;
			seen_rect.rect_bottom = res_ch.rect_bottom;
			if (pending_rects.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS) begin
					$display("%0t ns: unexpected result, expected none, actual frame %0d",
						$time, seen_rect.frame_index);
				end
			end else begin
				want_rect = pending_rects.pop_front();
				check_field("frame_index", 32'(want_rect.frame_index),
					32'(seen_rect.frame_index));
				check_field("done_flag", 32'(want_rect.done_flag),
					32'(seen_rect.done_flag));
				check_field("rect_left", 32'(want_rect.rect_left),
					32'(seen_rect.rect_left));
				check_field("rect_top", 32'(want_rect.rect_top),
					32'(seen_rect.rect_top));
				check_field("rect_right", 32'(want_rect.rect_right),
					32'(seen_rect.rect_right));
				check_field("rect_bottom", 32'(want_rect.rect_bottom),
					32'(seen_rect.rect_bottom));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset registers: start equals end, so ticks change nothing. Sets move
	// the frame; negative sets are dropped but still report.
	task automatic test_reset_defaults();
		send_tick('1);
		send_set(11'd1023);
		send_tick(20'd70000);
		send_set(11'h7FF);
		send_set(11'h400);
		send_set(11'd0);
		drain_results();
	endtask

	// Zero delay, zero columns and a zero-sized frame. With a zero timer a
	// zero tick holds, and every tick after that advances.
	task automatic test_zero_delay_and_sizes();
		cfg_write(REG_START_FRAME, 24'd0);
		cfg_write(REG_END_FRAME, 24'd9);
		cfg_write(REG_FRAME_DELAY, 24'd0);
		cfg_write(REG_COLUMNS, 24'd0);
		cfg_write(REG_SPRITE_WIDTH, 24'd0);
		cfg_write(REG_SPRITE_HEIGHT, 24'd0);
		// Dropped write: nothing above must move.
		cfg_write(REG_UNUSED, 24'hFFFFFF);
		send_tick(20'd0);
		send_tick(20'd1);
		send_tick(20'd0);
		send_set(11'd9);
		send_tick(20'd0);
		drain_results();
	endtask

	// Loop mode: exact delay plus leftover timer advances, a small tick holds,
	// the end wraps, and a frame below start wraps on the next advance.
	task automatic test_loop_wrap();
		cfg_write(REG_START_FRAME, 24'd3);
		cfg_write(REG_END_FRAME, 24'd6);
		cfg_write(REG_FRAME_DELAY, 24'd100);
		cfg_write(REG_LOOP_MODE, 24'd1);
		cfg_write(REG_COLUMNS, 24'd4);
		cfg_write(REG_SPRITE_WIDTH, 24'd16);
		cfg_write(REG_SPRITE_HEIGHT, 24'd8);
		send_set(11'd3);
		send_tick(20'd100);
		send_tick(20'd1);
		send_tick(20'd101);
		send_tick(20'd101);
		send_tick(20'd150);
		send_set(11'd0);
		send_tick(20'd120);
		drain_results();
	endtask

	// One-shot clamp at the top frame with the largest sheet, then a set
	// that clears the flag; then loop mode wraps past the largest index.
	task automatic test_range_edges();
		cfg_write(REG_START_FRAME, 24'd1022);
		cfg_write(REG_END_FRAME, 24'd1023);
		cfg_write(REG_FRAME_DELAY, 24'd1);
		cfg_write(REG_LOOP_MODE, 24'd0);
		cfg_write(REG_COLUMNS, 24'd255);
		cfg_write(REG_SPRITE_WIDTH, 24'd4095);
		cfg_write(REG_SPRITE_HEIGHT, 24'd4095);
		send_set(11'd1022);
		send_tick(20'd2);
		send_tick(20'd1);
		send_tick(20'd5);
		send_set(11'd1022);
		drain_results();
		cfg_write(REG_START_FRAME, 24'd0);
		cfg_write(REG_LOOP_MODE, 24'd1);
		send_set(11'd1023);
		send_tick(20'd2);
		drain_results();
	endtask

	// With a zero delay the timer only grows, so near-maximum ticks drive it
	// into saturation. The largest delay then drains it a frame per tick.
	task automatic test_accumulator_saturation();
		cfg_write(REG_START_FRAME, 24'd0);
		cfg_write(REG_END_FRAME, 24'd10);
		cfg_write(REG_FRAME_DELAY, 24'd0);
		cfg_write(REG_COLUMNS, 24'd3);
		send_set(11'd0);
		repeat (70) send_tick(DT_BITS'($urandom_range(20'hF0000, 20'hFFFFF)));
		send_tick('1);
		drain_results();
		cfg_write(REG_FRAME_DELAY, 24'hFFFFFF);
		repeat (6) send_tick(20'd0);
		drain_results();
	endtask

	// Hold the receiver off while the sender streams, so the result register
	// fills and the input stalls; then pause until everything is back.
	task automatic test_backpressure();
		random_config();
		src_idle_pct = 0;
		sink_idle_pct = 0;
		stall_requests++;
		repeat (14) send_random_item();
		drain_results();
	endtask

	// Random stimulus under one idle pattern, with fresh registers every few
	// dozen items.
	task automatic test_random_phase(input int unsigned src_pct, input int unsigned sink_pct);
		int unsigned sent;
		int unsigned burst;

		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			random_config();
			burst = $urandom_range(20, 60);
			repeat (burst) send_random_item();
			sent += burst;
			drain_results();
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		src_idle_pct   = 0;
		sink_idle_pct  = 0;
		stall_requests = 0;
		reset_sheet_model();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_zero_delay_and_sizes();
		test_loop_wrap();
		test_range_edges();
		test_accumulator_saturation();
		test_backpressure();
		test_random_phase(21, 85);
		test_random_phase(85, 21);
		test_random_phase(0, 0);

		drain_results();
		if (fail_count == 0) begin
			$display("sprite_animation_sequencer verification clean");
		end else begin
			$display("sprite_animation_sequencer verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/sas_pkg.sv
rtl/sas_if.sv
rtl/sas_ctrl.sv
rtl/sas_datapath.sv
rtl/sprite_animation_sequencer.sv
bench/sprite_animation_sequencer_tb.sv
